[rtl/mlpsf_pkg.sv]
// Shared types, constants and the sigmoid table builder for the MLP forward unit.
package mlpsf_pkg;

   localparam int ACT_W        = 16;   // Q4.12 activation / weight
   localparam int OUT_W        = 13;   // sigmoid output, 0..4096
   localparam int ROM_DEPTH    = 1024;
   localparam int ROM_AW       = 10;
   localparam int PROD_W       = 32;
   localparam int ACC_W        = 36;   // 17 terms of up to 2^30 each
   localparam int IDX_W        = 6;    // node / link index, wide enough for 64 nodes
   localparam int LAYER_W      = 2;    // at most four layers are addressable
   localparam int SIZE_W       = 5;
   localparam int LCNT_W       = 3;
   localparam int SIZE_REGS    = 4;
   localparam int DRAIN_CYCLES = 6;    // issue to layer-buffer write
   localparam int DRAIN_W      = 3;

   typedef enum logic [2:0] {
      REG_LAYER_COUNT = 3'd0,
      REG_SIZE_LAYER0 = 3'd1,
      REG_SIZE_LAYER1 = 3'd2,
      REG_SIZE_LAYER2 = 3'd3,
      REG_SIZE_LAYER3 = 3'd4
   } csr_index_type;

   typedef enum logic {
      CMD_WEIGHT = 1'b0,
      CMD_ACT    = 1'b1
   } cmd_type;

   typedef logic [ROM_DEPTH-1:0][OUT_W-1:0] rom_type;

   // clamped configuration seen by the controller
   typedef struct packed {
      logic [LCNT_W-1:0]                 layers;
      logic [SIZE_REGS-1:0][SIZE_W-1:0]  size;
   } cfg_type;

   // controller to datapath, one per cycle
   typedef struct packed {
      logic               issue;      // MAC step this cycle
      logic               bias;       // step adds the node bias
      logic               first;      // first link of a node
      logic [LAYER_W-1:0] layer;      // layer being computed / last layer on emit
      logic [IDX_W-1:0]   k;          // incoming link
      logic [IDX_W-1:0]   node;       // node being computed / emitted
      logic               emit;       // send one result item
      logic               emit_last;
   } dp_cmd_type;

   // shift-subtract divide, elaboration only
   function automatic logic [63:0] udiv(input logic [63:0] num, input logic [63:0] den);
      logic [64:0] rem;
      logic [63:0] quo;
      rem = '0;
      quo = '0;
      for (int i = 63; i >= 0; i--) begin
         rem = {rem[63:0], num[i]};
         if (rem >= {1'b0, den}) begin
            rem    = rem - {1'b0, den};
            quo[i] = 1'b1;
         end
      end
      return quo;
   endfunction

   function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
      logic [127:0] prod;
      prod = {64'd0, a} * {64'd0, b};
      return prod[125:62];
   endfunction

   // entry i = round(4096 * sigmoid(-8 + (i + 0.5) / 64)), exact integer build
   function automatic rom_type build_sig_rom();
      logic [63:0] term;
      logic [63:0] q;
      logic [63:0] p;
      logic [63:0] p40;
      logic [63:0] den;
      rom_type     rom;
      term = 64'd1 << 62;
      q    = term;
      p    = term;
      rom  = '0;
      for (int n = 1; n <= 15; n++) begin
         term = udiv(term, 64'(128 * n));
         if ((n % 2) == 1) q = q - term;
         else              q = q + term;
      end
      for (int k = 1; k < ROM_DEPTH; k++) begin
         p = mul_q62(p, q);
         if ((k % 2) == 1) begin
            p40 = p >> 22;
            den = (64'd1 << 40) + p40;
            rom[(k + 1023) / 2] = OUT_W'(udiv((64'd1 << 53) + den, den << 1));
            rom[(1023 - k) / 2] = OUT_W'(udiv((p40 << 13) + den, den << 1));
         end
      end
      return rom;
   endfunction

endpackage

[rtl/mlpsf_controller.sv]
// Sequencer for the forward pass: link, node and layer counters and result emission.
module mlpsf_controller #(
   parameter int MAX_WIDTH    = 16,
   parameter int WEIGHT_DEPTH = 1024
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start_pass,
   input  mlpsf_pkg::cfg_type          cfg,
   output mlpsf_pkg::dp_cmd_type       cmd,
   output logic [$clog2(WEIGHT_DEPTH)-1:0] rd_addr,
   output logic                        busy
);
   import mlpsf_pkg::*;

   localparam int AW = $clog2(WEIGHT_DEPTH);
   localparam int KW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_RUN   = 4'b0010,
      ST_DRAIN = 4'b0100,
      ST_EMIT  = 4'b1000
   } state_type;

   state_type          state_ff, state_in;
   logic [LAYER_W-1:0] layer_ff, layer_in;
   logic [KW-1:0]      node_ff, node_in;
   logic [KW-1:0]      k_ff, k_in;
   logic               bias_ff, bias_in;
   logic [AW-1:0]      addr_ff, addr_in;
   logic [DRAIN_W-1:0] drain_ff, drain_in;

   logic [SIZE_W-1:0]  n_prev;
   logic [SIZE_W-1:0]  n_cur;
   logic               k_end;
   logic               node_end;
   logic               layer_end;

   assign n_prev    = cfg.size[layer_ff - LAYER_W'(1)];
   assign n_cur     = cfg.size[layer_ff];
   assign k_end     = int'(k_ff) == int'(n_prev) - 1;
   assign node_end  = int'(node_ff) == int'(n_cur) - 1;
   assign layer_end = int'(layer_ff) == int'(cfg.layers) - 1;

   always_comb begin
      state_in      = state_ff;
      layer_in      = layer_ff;
      node_in       = node_ff;
      k_in          = k_ff;
      bias_in       = bias_ff;
      addr_in       = addr_ff;
      drain_in      = drain_ff;
      cmd           = '0;
      cmd.layer     = layer_ff;
      cmd.k         = IDX_W'(k_ff);
      cmd.node      = IDX_W'(node_ff);
      cmd.bias      = bias_ff;
      cmd.first     = !bias_ff && (k_ff == '0);
      cmd.emit_last = node_end;
      unique case (state_ff)
         ST_IDLE: begin
            if (start_pass) begin
               state_in = ST_RUN;
               layer_in = LAYER_W'(1);
               node_in  = '0;
               k_in     = '0;
               bias_in  = 1'b0;
               addr_in  = '0;
            end
         end
         ST_RUN: begin
            cmd.issue = 1'b1;
            addr_in   = addr_ff + AW'(1);
            if (!bias_ff) begin
               if (k_end) bias_in = 1'b1;
               else       k_in    = k_ff + KW'(1);
            end else begin
               bias_in = 1'b0;
               k_in    = '0;
               if (node_end) begin
                  node_in  = '0;
                  drain_in = '0;
                  state_in = ST_DRAIN;
               end else begin
                  node_in = node_ff + KW'(1);
               end
            end
         end
         ST_DRAIN: begin
            drain_in = drain_ff + DRAIN_W'(1);
            if (int'(drain_ff) == DRAIN_CYCLES - 1) begin
               if (layer_end) begin
                  state_in = ST_EMIT;
               end else begin
                  layer_in = layer_ff + LAYER_W'(1);
                  state_in = ST_RUN;
               end
            end
         end
         ST_EMIT: begin
            cmd.emit = 1'b1;
            node_in  = node_ff + KW'(1);
            if (node_end) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         layer_ff <= LAYER_W'(1);
         node_ff  <= '0;
         k_ff     <= '0;
         bias_ff  <= 1'b0;
         addr_ff  <= '0;
         drain_ff <= '0;
      end else begin
         state_ff <= state_in;
         layer_ff <= layer_in;
         node_ff  <= node_in;
         k_ff     <= k_in;
         bias_ff  <= bias_in;
         addr_ff  <= addr_in;
         drain_ff <= drain_in;
      end
   end

   assign rd_addr = addr_ff;
   assign busy    = (state_ff != ST_IDLE);

endmodule

[rtl/mlpsf_datapath.sv]
// Weight and activation stores, shared MAC pipeline, sigmoid ROM and result register.
module mlpsf_datapath #(
   parameter int MAX_WIDTH    = 16,
   parameter int WEIGHT_DEPTH = 1024
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            accept,
   input  logic                            in_cmd,
   input  logic [9:0]                      in_position,
   input  logic signed [15:0]              in_value,
   input  logic [4:0]                      size0,
   input  mlpsf_pkg::dp_cmd_type           cmd,
   input  logic [$clog2(WEIGHT_DEPTH)-1:0] rd_addr,
   output logic                            rsp_strobe,
   output logic [12:0]                     rsp_activation,
   output logic [3:0]                      rsp_node_index,
   output logic                            rsp_last_output
);
   import mlpsf_pkg::*;

   localparam int AW = $clog2(WEIGHT_DEPTH);
   localparam int KW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam rom_type SIG_ROM = build_sig_rom();

   logic signed [ACT_W-1:0] wmem_ff [WEIGHT_DEPTH];
   logic signed [ACT_W-1:0] inp_ff  [MAX_WIDTH];
   logic [OUT_W-1:0]        abuf_ff [2][MAX_WIDTH];

   logic wr_weight, wr_act;
   assign wr_weight = accept && (in_cmd == CMD_WEIGHT);
   assign wr_act    = accept && (in_cmd == CMD_ACT) && ({5'd0, in_position} < {10'd0, size0});

   // weight store: one write port, one registered read port
   logic signed [ACT_W-1:0] w_rd_ff;
   always_ff @(posedge clock) begin
      if (wr_weight) wmem_ff[AW'(in_position)] <= in_value;
      w_rd_ff <= wmem_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (wr_act) inp_ff[in_position[KW-1:0]] <= in_value;
   end

   // previous-layer activation for this link
   logic signed [ACT_W-1:0] act_sel;
   always_comb begin
      if (cmd.layer == LAYER_W'(1)) act_sel = inp_ff[cmd.k[KW-1:0]];
      else act_sel = signed'({3'd0, abuf_ff[cmd.layer[0]][cmd.k[KW-1:0]]});
   end

   dp_cmd_type                t1_ff, t2_ff, t3_ff;
   logic signed [ACT_W-1:0]   act_ff;
   logic signed [PROD_W-1:0]  prod_ff;
   logic signed [ACC_W-1:0]   acc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         t1_ff <= '0;
         t2_ff <= '0;
         t3_ff <= '0;
      end else begin
         t1_ff <= cmd;
         t2_ff <= t1_ff;
         t3_ff <= t2_ff;
      end
   end

   always_ff @(posedge clock) begin
      act_ff <= act_sel;
      if (t1_ff.bias) prod_ff <= {{4{w_rd_ff[ACT_W-1]}}, w_rd_ff, 12'd0};
      else            prod_ff <= act_ff * w_rd_ff;
      if (t2_ff.issue) begin
         if (t2_ff.first) acc_ff <= ACC_W'(prod_ff);
         else             acc_ff <= acc_ff + ACC_W'(prod_ff);
      end
   end

   // round half up to Q4.12, saturate to [-8, 8), form the ROM index
   logic signed [ACC_W-1:0] rnd;
   logic signed [ACT_W-1:0] sat;
   always_comb begin
      rnd = (acc_ff + ACC_W'(2048)) >>> 12;
      if (rnd > ACC_W'(32767))       sat = 16'sh7fff;
      else if (rnd < ACC_W'(-32768)) sat = 16'sh8000;
      else                           sat = rnd[ACT_W-1:0];
   end

   logic                v4_ff, v5_ff;
   logic [ROM_AW-1:0]   idx_ff;
   logic [IDX_W-1:0]    node4_ff, node5_ff;
   logic [LAYER_W-1:0]  layer4_ff, layer5_ff;
   logic [OUT_W-1:0]    rom_q_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         v4_ff <= t3_ff.issue && t3_ff.bias;
         v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff    <= {~sat[15], sat[14:6]};
      node4_ff  <= t3_ff.node;
      layer4_ff <= t3_ff.layer;
      rom_q_ff  <= SIG_ROM[idx_ff];
      node5_ff  <= node4_ff;
      layer5_ff <= layer4_ff;
      // odd layers land in buffer 0, even layers in buffer 1
      if (v5_ff) abuf_ff[~layer5_ff[0]][node5_ff[KW-1:0]] <= rom_q_ff;
   end

   // result register
   logic             strobe_ff;
   logic [OUT_W-1:0] out_act_ff;
   logic [3:0]       out_node_ff;
   logic             out_last_ff;

   always_ff @(posedge clock) begin
      if (reset) strobe_ff <= 1'b0;
      else       strobe_ff <= cmd.emit;
      out_act_ff  <= abuf_ff[~cmd.layer[0]][cmd.node[KW-1:0]];
      out_node_ff <= cmd.node[3:0];
      out_last_ff <= cmd.emit_last;
   end

   assign rsp_strobe      = strobe_ff;
   assign rsp_activation  = out_act_ff;
   assign rsp_node_index  = out_node_ff;
   assign rsp_last_output = out_last_ff;

endmodule

[rtl/mlp_sigmoid_forward_unit.sv]
// Top level of the sigmoid MLP forward unit: CSR block, controller and datapath.
//
//  channel | ports                                   | handshake
//  --------+-----------------------------------------+-----------------------------
//  request | req_cmd req_position req_value           | taken when req_start and
//          | req_final_input                         | not req_busy
//  result  | rsp_activation rsp_node_index            | one cycle on rsp_strobe,
//          | rsp_last_output                         | never held off
//  csr     | psel penable pwrite paddr pwdata prdata | write on access phase,
//          | pready                                  | pready tied high
//
// Weight writes and non-final input items are taken without raising req_busy.
// A final input item starts a pass: each layer runs its links and a bias step for
// every node on the single shared multiplier and the one weight read port, then
// drains the MAC/ROM pipeline; after the last layer the output items follow, one per cycle.
// Reset is synchronous; it restores the CSRs, not the weight or input stores.
// Results leave through a register, so a new item can be taken on the cycle
// the last result of a pass is shown.
module mlp_sigmoid_forward_unit #(
   parameter int MAX_LAYERS   = 4,
   parameter int MAX_WIDTH    = 16,
   parameter int WEIGHT_DEPTH = 1024
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_start,
   output logic               req_busy,
   input  logic               req_cmd,
   input  logic [9:0]         req_position,
   input  logic signed [15:0] req_value,
   input  logic               req_final_input,
   output logic               rsp_strobe,
   output logic [12:0]        rsp_activation,
   output logic [3:0]         rsp_node_index,
   output logic               rsp_last_output,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [4:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);
   import mlpsf_pkg::*;

   localparam int AW        = $clog2(WEIGHT_DEPTH);
   localparam int LAYER_CAP = (MAX_LAYERS < SIZE_REGS) ? MAX_LAYERS : SIZE_REGS;

   // raw CSR contents, read back as written
   logic [LCNT_W-1:0]                layer_count_ff;
   logic [SIZE_REGS-1:0][SIZE_W-1:0] size_ff;
   csr_index_type                    csr_idx;
   logic                             csr_wr;

   assign pready  = 1'b1;
   assign csr_idx = csr_index_type'(paddr[4:2]);
   assign csr_wr  = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         layer_count_ff <= LCNT_W'(3);
         size_ff        <= {SIZE_REGS{SIZE_W'(16)}};
      end else if (csr_wr) begin
         unique case (csr_idx)
            REG_LAYER_COUNT: layer_count_ff <= pwdata[LCNT_W-1:0];
            REG_SIZE_LAYER0: size_ff[0]     <= pwdata[SIZE_W-1:0];
            REG_SIZE_LAYER1: size_ff[1]     <= pwdata[SIZE_W-1:0];
            REG_SIZE_LAYER2: size_ff[2]     <= pwdata[SIZE_W-1:0];
            REG_SIZE_LAYER3: size_ff[3]     <= pwdata[SIZE_W-1:0];
            default: ;  // unmapped addresses are ignored
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         REG_LAYER_COUNT: prdata = 32'(layer_count_ff);
         REG_SIZE_LAYER0: prdata = 32'(size_ff[0]);
         REG_SIZE_LAYER1: prdata = 32'(size_ff[1]);
         REG_SIZE_LAYER2: prdata = 32'(size_ff[2]);
         REG_SIZE_LAYER3: prdata = 32'(size_ff[3]);
         default:         prdata = '0;
      endcase
   end

   // clamp: layers to [2, cap], sizes to [1, MAX_WIDTH]
   cfg_type cfg;
   always_comb begin
      if (int'(layer_count_ff) < 2)              cfg.layers = LCNT_W'(2);
      else if (int'(layer_count_ff) > LAYER_CAP) cfg.layers = LCNT_W'(LAYER_CAP);
      else                                       cfg.layers = layer_count_ff;
      for (int i = 0; i < SIZE_REGS; i++) begin
         if (size_ff[i] == '0)                 cfg.size[i] = SIZE_W'(1);
         else if (int'(size_ff[i]) > MAX_WIDTH) cfg.size[i] = SIZE_W'(MAX_WIDTH);
         else                                  cfg.size[i] = size_ff[i];
      end
   end

   logic       accept;
   logic       start_pass;
   dp_cmd_type cmd;
   logic [AW-1:0] rd_addr;

   assign accept     = req_start && !req_busy;
   assign start_pass = accept && (req_cmd == CMD_ACT) && req_final_input;

   mlpsf_controller #(
      .MAX_WIDTH    (MAX_WIDTH),
      .WEIGHT_DEPTH (WEIGHT_DEPTH)
   ) u_ctl (
      .clock      (clock),
      .reset      (reset),
      .start_pass (start_pass),
      .cfg        (cfg),
      .cmd        (cmd),
      .rd_addr    (rd_addr),
      .busy       (req_busy)
   );

   mlpsf_datapath #(
      .MAX_WIDTH    (MAX_WIDTH),
      .WEIGHT_DEPTH (WEIGHT_DEPTH)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .accept          (accept),
      .in_cmd          (req_cmd),
      .in_position     (req_position),
      .in_value        (req_value),
      .size0           (cfg.size[0]),
      .cmd             (cmd),
      .rd_addr         (rd_addr),
      .rsp_strobe      (rsp_strobe),
      .rsp_activation  (rsp_activation),
      .rsp_node_index  (rsp_node_index),
      .rsp_last_output (rsp_last_output)
   );

endmodule

[rtl/mlpsf_checker.sv]
// Port-level checks for the MLP forward unit and their bind to the top level.
module mlpsf_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_start,
   input logic       req_busy,
   input logic       req_cmd,
   input logic       req_final_input,
   input logic       rsp_strobe,
   input logic [3:0] rsp_node_index,
   input logic       rsp_last_output
);
   import mlpsf_pkg::*;

   logic accept;
   assign accept = req_start && !req_busy;

   // a final input item always starts a pass
   a_pass_starts: assert property (@(posedge clock) disable iff (reset)
      accept && (req_cmd == CMD_ACT) && req_final_input |=> req_busy)
      else $error("final input did not start a pass");

   // other items never start one
   a_no_pass: assert property (@(posedge clock) disable iff (reset)
      accept && !((req_cmd == CMD_ACT) && req_final_input) |=> !req_busy)
      else $error("non-final item raised busy");

   // results of a pass come back to back, node indexes counting up
   a_burst: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_last_output |=>
         rsp_strobe && (rsp_node_index == 4'($past(rsp_node_index) + 4'd1)))
      else $error("result burst broken");

   a_burst_end: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_last_output |=> !rsp_strobe)
      else $error("result after last item");

   // a burst opens at node zero
   a_first_node: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_strobe) |-> (rsp_node_index == 4'd0))
      else $error("burst did not start at node zero");

endmodule

bind mlp_sigmoid_forward_unit mlpsf_checker u_mlpsf_checker (.*);
